/* sv/buddhabrot_orbit_accumulator_unit_macros.svh */
// ----------------------------------------------------------------------------
// buddhabrot orbit accumulator assertion macros
// shared assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BUDDHABROT_ORBIT_ACCUMULATOR_UNIT_MACROS_SVH
`define BUDDHABROT_ORBIT_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BOACC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BOACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/boacc_pkg.sv */
// ----------------------------------------------------------------------------
// boacc_pkg
// shared constants, types and codes of the orbit accumulator
// ----------------------------------------------------------------------------
package boacc_pkg;

  localparam int FRAC_BITS = 28;
  localparam int LOG2_MAX  = 8;
  localparam int SIDE_MAX  = 1 << LOG2_MAX;
  localparam int POS_W     = 8;
  localparam int ADDR_W    = 2 * LOG2_MAX;
  localparam int MEM_DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int FIX_W     = 32;
  localparam int PROD_W    = 2 * FIX_W - FRAC_BITS;
  localparam int CNT_W     = 16;
  localparam int LOG_W     = 4;
  localparam int SH_W      = 5;
  localparam int LVL_W     = 8;
  localparam int PIX_W     = 2 * LVL_W;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  localparam logic [LOG_W-1:0] SIZE_RESET  = LOG_W'(8);
  localparam logic [CNT_W-1:0] ITERS_RESET = CNT_W'(1000);
  localparam logic [LVL_W-1:0] STEP_RESET  = LVL_W'(20);

  // register indexes
  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_ITERS = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDPIX,
    S_EPROD,
    S_EUPD,
    S_RPROD,
    S_RUPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic mem_rd;
    logic prod;
    logic pix_rd;
    logic advance;
    logic restart;
    logic plot;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_read;
    logic in_grid;
    logic esc_hit;
    logic cnt_eq_max;
    logic cnt_eq_n;
  } stat_t;

endpackage

/* sv/boacc_intf.sv */
// ----------------------------------------------------------------------------
// boacc request and result channels
// valid/ready channels carrying the request and result payloads
// ----------------------------------------------------------------------------
interface boacc_in_if;
  import boacc_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  modport source (output valid, req_type, pos_x, pos_y, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, output ready);
endinterface

interface boacc_out_if;
  import boacc_pkg::*;
  logic             valid;
  logic             ready;
  logic             escaped;
  logic [CNT_W-1:0] orbit_steps;
  logic [LVL_W-1:0] red_level;
  logic [LVL_W-1:0] blue_level;
  modport source (output valid, escaped, orbit_steps, red_level, blue_level, input ready);
  modport sink (input valid, escaped, orbit_steps, red_level, blue_level, output ready);
endinterface

/* sv/boacc_regs.sv */
// ----------------------------------------------------------------------------
// boacc_regs
// apb configuration registers and effective image size
// ----------------------------------------------------------------------------
module boacc_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [boacc_pkg::CFG_AW-1:0]   paddr,
  input  logic [boacc_pkg::CFG_DW-1:0]   pwdata,
  output logic [boacc_pkg::CFG_DW-1:0]   prdata,
  output logic                           pready,
  output logic [boacc_pkg::LOG_W-1:0]    eff_log2,
  output logic [boacc_pkg::CNT_W-1:0]    iter_limit,
  output logic [boacc_pkg::LVL_W-1:0]    step
);
  import boacc_pkg::*;

  logic [LOG_W-1:0] size_r;
  logic [CNT_W-1:0] iters_r;
  logic [LVL_W-1:0] step_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RESET;
      iters_r <= ITERS_RESET;
      step_r  <= STEP_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SIZE:  size_r  <= pwdata[LOG_W-1:0];
        REG_ITERS: iters_r <= pwdata[CNT_W-1:0];
        REG_STEP:  step_r  <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIZE:  prdata = CFG_DW'(size_r);
      REG_ITERS: prdata = CFG_DW'(iters_r);
      REG_STEP:  prdata = CFG_DW'(step_r);
      default:   prdata = '0;
    endcase
  end

  // cap at the largest side the store holds
  assign eff_log2   = (size_r > LOG_W'(LOG2_MAX)) ? LOG_W'(LOG2_MAX) : size_r;
  assign iter_limit = iters_r;
  assign step       = step_r;

endmodule

/* sv/boacc_ctrl.sv */
// ----------------------------------------------------------------------------
// boacc_ctrl
// sequencer for clearing, escape test, orbit replay and pixel reads
// ----------------------------------------------------------------------------
module boacc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_ready,
  input  boacc_pkg::stat_t stat,
  output boacc_pkg::cmd_t  cmd,
  output logic             in_ready,
  output logic             out_valid
);
  import boacc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (stat.in_read)      state_nxt = S_RDPIX;
          else if (stat.in_grid) state_nxt = S_EPROD;
          else                   state_nxt = S_DONE;
        end
      end
      S_RDPIX: state_nxt = S_DONE;
      S_EPROD: state_nxt = S_EUPD;
      S_EUPD: begin
        if (stat.esc_hit)         state_nxt = S_RPROD;
        else if (stat.cnt_eq_max) state_nxt = S_DONE;
        else                      state_nxt = S_EPROD;
      end
      S_RPROD: state_nxt = S_RUPD;
      S_RUPD:  state_nxt = stat.cnt_eq_n ? S_DONE : S_RPROD;
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_RDPIX: cmd.mem_rd = 1'b1;
      S_EPROD: cmd.prod = 1'b1;
      S_EUPD: begin
        cmd.restart = stat.esc_hit;
        cmd.advance = !stat.esc_hit && !stat.cnt_eq_max;
      end
      S_RPROD: begin
        cmd.prod   = 1'b1;
        cmd.pix_rd = 1'b1;
      end
      S_RUPD: begin
        cmd.plot    = 1'b1;
        cmd.advance = !stat.cnt_eq_n;
      end
      S_DONE:  cmd.out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/boacc_dp.sv */
// ----------------------------------------------------------------------------
// boacc_dp
// fixed-point orbit datapath, pixel mapping and red/blue image store
// ----------------------------------------------------------------------------
module boacc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  boacc_pkg::cmd_t               cmd,
  input  logic [boacc_pkg::LOG_W-1:0]   eff_log2,
  input  logic [boacc_pkg::CNT_W-1:0]   iter_limit,
  input  logic [boacc_pkg::LVL_W-1:0]   step,
  input  logic                          in_req_type,
  input  logic [boacc_pkg::POS_W-1:0]   in_pos_x,
  input  logic [boacc_pkg::POS_W-1:0]   in_pos_y,
  output boacc_pkg::stat_t              stat,
  output logic                          out_escaped,
  output logic [boacc_pkg::CNT_W-1:0]   out_orbit_steps,
  output logic [boacc_pkg::LVL_W-1:0]   out_red_level,
  output logic [boacc_pkg::LVL_W-1:0]   out_blue_level
);
  import boacc_pkg::*;

  localparam int XW = PROD_W + 2;
  localparam logic signed [FIX_W-1:0] TWO_FIX = FIX_W'(2) << FRAC_BITS;
  localparam logic [PROD_W:0] FOUR_SQ = (PROD_W+1)'(4) << FRAC_BITS;

  logic [PIX_W-1:0] img_mem [0:MEM_DEPTH-1];

  logic [ADDR_W-1:0]       clr_addr_r;
  logic [POS_W-1:0]        x_r, y_r;
  logic                    type_r, esc_r;
  logic signed [FIX_W-1:0] cr_r, ci_r, zr_r, zi_r;
  logic [PROD_W-1:0]       xx_r, yy_r, xy_r;
  logic                    xy_neg_r;
  logic [CNT_W-1:0]        cnt_r, n_r;
  logic                    pv_r;
  logic [ADDR_W-1:0]       pa_r;
  logic [PIX_W-1:0]        rd_data_r;

  logic [POS_W:0]          side;
  logic [SH_W-1:0]         sh;
  logic signed [FIX_W-1:0] c_x, c_y;
  logic [FIX_W-1:0]        zr_mag, zi_mag;
  logic [2*FIX_W-1:0]      p_xx, p_yy, p_xy;
  logic signed [XW-1:0]    sxy, zr_sum, zi_sum;
  logic [PROD_W:0]         mag_sq;
  logic [POS_W:0]          map_x, map_y;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    rd_ok;

  function automatic logic [POS_W:0] pix_map(input logic signed [FIX_W-1:0] v,
                                             input logic [SH_W-1:0] shv,
                                             input logic [POS_W:0] sd);
    logic signed [FIX_W:0] t;
    logic [FIX_W:0]        m;
    logic [FIX_W:0]        q;
    logic                  ok;
    logic [POS_W-1:0]      p;
    t = {v[FIX_W-1], v} + {TWO_FIX[FIX_W-1], TWO_FIX};
    m = t[FIX_W] ? (~t + 1'b1) : t;
    q = m >> shv;
    // small negative offsets still land on the first pixel
    if (t[FIX_W]) begin
      ok = (q == '0);
      p  = '0;
    end else begin
      ok = (q < {{(FIX_W-POS_W){1'b0}}, sd});
      p  = q[POS_W-1:0];
    end
    return {ok, p};
  endfunction

  function automatic logic [LVL_W-1:0] sat_add(input logic [LVL_W-1:0] a,
                                              input logic [LVL_W-1:0] b);
    logic [LVL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LVL_W] ? {LVL_W{1'b1}} : s[LVL_W-1:0];
  endfunction

  assign side = (POS_W+1)'(1) << eff_log2;
  assign sh   = SH_W'(FRAC_BITS + 2) - SH_W'(eff_log2);
  assign c_x  = $signed(FIX_W'(in_pos_x) << sh) - TWO_FIX;
  assign c_y  = $signed(FIX_W'(in_pos_y) << sh) - TWO_FIX;

  assign zr_mag = zr_r[FIX_W-1] ? FIX_W'(-zr_r) : FIX_W'(zr_r);
  assign zi_mag = zi_r[FIX_W-1] ? FIX_W'(-zi_r) : FIX_W'(zi_r);
  assign p_xx   = zr_mag * zr_mag;
  assign p_yy   = zi_mag * zi_mag;
  assign p_xy   = zr_mag * zi_mag;

  assign sxy    = xy_neg_r ? -$signed({2'b00, xy_r}) : $signed({2'b00, xy_r});
  assign zr_sum = $signed({2'b00, xx_r}) - $signed({2'b00, yy_r}) + XW'(cr_r);
  assign zi_sum = (sxy <<< 1) + XW'(ci_r);
  assign mag_sq = {1'b0, xx_r} + {1'b0, yy_r};

  assign map_x = pix_map(zr_r, sh, side);
  assign map_y = pix_map(zi_r, sh, side);

  assign stat.clr_done   = (clr_addr_r == '1);
  assign stat.in_read    = in_req_type;
  assign stat.in_grid    = ({1'b0, in_pos_x} < side) && ({1'b0, in_pos_y} < side);
  assign stat.esc_hit    = (mag_sq > FOUR_SQ) && (cnt_r != '0);
  assign stat.cnt_eq_max = (cnt_r == iter_limit);
  assign stat.cnt_eq_n   = (cnt_r == n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr) clr_addr_r <= clr_addr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      type_r <= in_req_type;
      cr_r   <= c_x;
      ci_r   <= c_y;
      zr_r   <= '0;
      zi_r   <= '0;
      cnt_r  <= '0;
      n_r    <= '0;
      esc_r  <= 1'b0;
    end else if (cmd.restart) begin
      zr_r  <= '0;
      zi_r  <= '0;
      n_r   <= cnt_r;
      cnt_r <= '0;
      esc_r <= 1'b1;
    end else if (cmd.advance) begin
      zr_r  <= zr_sum[FIX_W-1:0];
      zi_r  <= zi_sum[FIX_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.prod) begin
      xx_r     <= p_xx[2*FIX_W-1:FRAC_BITS];
      yy_r     <= p_yy[2*FIX_W-1:FRAC_BITS];
      xy_r     <= p_xy[2*FIX_W-1:FRAC_BITS];
      xy_neg_r <= zr_r[FIX_W-1] ^ zi_r[FIX_W-1];
    end
    if (cmd.pix_rd) begin
      pv_r <= map_x[POS_W] && map_y[POS_W] && (cnt_r != '0);
      pa_r <= {map_y[POS_W-1:0], map_x[POS_W-1:0]};
    end
  end

  assign rd_addr = cmd.pix_rd ? {map_y[POS_W-1:0], map_x[POS_W-1:0]} : {y_r, x_r};

  always_ff @(posedge clk) begin
    if (cmd.pix_rd || cmd.mem_rd) rd_data_r <= img_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      img_mem[clr_addr_r] <= '0;
    end else if (cmd.plot && pv_r) begin
      img_mem[pa_r] <= {sat_add(rd_data_r[PIX_W-1:LVL_W], step),
                        sat_add(rd_data_r[LVL_W-1:0], step)};
    end
  end

  assign rd_ok = ({1'b0, x_r} < side) && ({1'b0, y_r} < side);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_escaped     <= !type_r && esc_r;
      out_orbit_steps <= type_r ? '0 : n_r;
      out_red_level   <= (type_r && rd_ok) ? rd_data_r[LVL_W-1:0] : '0;
      out_blue_level  <= (type_r && rd_ok) ? rd_data_r[PIX_W-1:LVL_W] : '0;
    end
  end

endmodule

/* sv/buddhabrot_orbit_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// buddhabrot_orbit_accumulator_unit
// After reset the block clears its 65536-entry red/blue image store, one
// entry a cycle, and takes no request until the clear is done (register
// writes are taken). A trace request maps its grid point to c and runs
// z = z^2 + c in Q4.28 on three shared 32x32 multipliers: each escape-test
// iteration forms the products, then does the update and |z|^2 compare; a
// first pass checks the starting z = 0, and a point that never escapes stops
// at the iteration limit. An escaping point is replayed step by step, again
// with a first pass for z = 0; the image store's single read port and write
// port carry the read-modify-write of each visited pixel within the step,
// reading with the products and writing with the update. A read request
// reads its pixel from the store, and a point outside the grid goes straight
// to the result load. Results leave through an output register, so the next
// request is taken while one waits to be collected.
// ----------------------------------------------------------------------------
module buddhabrot_orbit_accumulator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  boacc_in_if.sink                     in_req,
  boacc_out_if.source                  out_res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [boacc_pkg::CFG_AW-1:0] paddr,
  input  logic [boacc_pkg::CFG_DW-1:0] pwdata,
  output logic [boacc_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);
  import boacc_pkg::*;

  // effective settings
  logic [LOG_W-1:0] eff_log2;
  logic [CNT_W-1:0] iter_limit;
  logic [LVL_W-1:0] step;

  // controller / datapath handshake
  cmd_t  cmd;
  stat_t stat;

  boacc_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .eff_log2   (eff_log2),
    .iter_limit (iter_limit),
    .step       (step)
  );

  // sequencer owns both the request and result handshakes
  boacc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .out_ready (out_res.ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid)
  );

  // orbit arithmetic, image store and result register
  boacc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .eff_log2        (eff_log2),
    .iter_limit      (iter_limit),
    .step            (step),
    .in_req_type     (in_req.req_type),
    .in_pos_x        (in_req.pos_x),
    .in_pos_y        (in_req.pos_y),
    .stat            (stat),
    .out_escaped     (out_res.escaped),
    .out_orbit_steps (out_res.orbit_steps),
    .out_red_level   (out_res.red_level),
    .out_blue_level  (out_res.blue_level)
  );

  `include "buddhabrot_orbit_accumulator_unit_macros.svh"

  // ready is low in the cycle after a request is accepted
  `BOACC_ASSERT_NEXT(a_busy_after_accept, in_req.valid && in_req.ready, !in_req.ready, "ready right after accept")
  // an escaped trace always reports a nonzero step count
  `BOACC_ASSERT_NOW(a_esc_steps, out_res.valid && out_res.escaped, out_res.orbit_steps != '0, "escaped with zero steps")
  // an escaped trace result carries no pixel levels
  `BOACC_ASSERT_NOW(a_esc_no_levels, out_res.valid && out_res.escaped, (out_res.red_level == '0) && (out_res.blue_level == '0), "levels on trace result")

endmodule
